### design/lambert_diffuse_shade_defines.svh
// Assertion macros shared by the diffuse shading block.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef LAMBERT_DIFFUSE_SHADE_DEFINES_SVH
`define LAMBERT_DIFFUSE_SHADE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LDS_ASSERT_IMP(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("lds: assertion failed");
`define LDS_ASSERT_NXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("lds: assertion failed");
`else
`define LDS_ASSERT_IMP(name, clock, reset, ante, cons)
`define LDS_ASSERT_NXT(name, clock, reset, ante, cons)
`endif
`endif

### design/lds_pkg.sv
// Types, widths and register codes of the diffuse shading block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package lds_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int BITLEN_W    = $clog2(DIFF_W + 1);
  localparam int NORM_W      = 30;
  localparam int SQ_W        = 2 * NORM_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int RES_W       = SUM_W + 1;
  localparam int ISQ_STEPS   = SUM_W / 2 + 1;
  localparam int ROOT_W      = NORM_W + 1;
  localparam int QUO_W       = ROOT_W + 1;
  localparam int NRM_W       = 16;
  localparam int OC_W        = 16;
  localparam int COL_W       = 25;

  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int DATA_W    = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int ADDR_LSB  = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int ADDR_W    = ADDR_LSB + REG_IDX_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LIGHT_POS_X = 3'd0,
    REG_LIGHT_POS_Y = 3'd1,
    REG_LIGHT_POS_Z = 3'd2,
    REG_LIGHT_RED   = 3'd3,
    REG_LIGHT_GREEN = 3'd4,
    REG_LIGHT_BLUE  = 3'd5,
    REG_BRIGHTNESS  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [7:0]                    obj_red;
    logic [7:0]                    obj_green;
    logic [7:0]                    obj_blue;
    logic signed [COORD_WIDTH-1:0] hit_x;
    logic signed [COORD_WIDTH-1:0] hit_y;
    logic signed [COORD_WIDTH-1:0] hit_z;
    logic signed [NRM_W-1:0]       normal_x;
    logic signed [NRM_W-1:0]       normal_y;
    logic signed [NRM_W-1:0]       normal_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] diffuse_red;
    logic [7:0] diffuse_green;
    logic [7:0] diffuse_blue;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] light_pos_x;
    logic signed [COORD_WIDTH-1:0] light_pos_y;
    logic signed [COORD_WIDTH-1:0] light_pos_z;
    logic [7:0]                    light_red;
    logic [7:0]                    light_green;
    logic [7:0]                    light_blue;
    logic [8:0]                    brightness;
  } cfg_t;

  // Data that rides alongside the root and reciprocal pipelines.
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   zero;
    logic [2:0][NRM_W-1:0]  normal;
    logic [2:0][COL_W-1:0]  colour;
  } side_t;

endpackage
`default_nettype wire

### design/lambert_diffuse_shade.sv
// Lambertian diffuse shading of one ray hit per clock. A hit is taken on any
// cycle with start high; busy is always low. Its colour appears on result
// with done high for one cycle, in the order the hits came in; the receiver
// must take it then, as results cannot be held back. The path runs through
// the 32-stage square root and the 32-stage reciprocal, framed by five stages
// before and five after.
// Light position, colour and brightness are written over the APB-style port;
// the user writes them only while no transaction is in flight, which the block does not enforce.
`default_nettype none
module lambert_diffuse_shade import lds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item,
  output logic              done,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t              cfg;
  logic              nv;
  logic [SUM_W-1:0]  nsum;
  side_t             nside;
  logic              rv;
  logic [ROOT_W-1:0] rroot;
  side_t             rside;
  logic              qv;
  logic [QUO_W-1:0]  qquo;
  side_t             qside;

  assign busy = 1'b0;

  lds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lds_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_item   (item),
    .cfg       (cfg),
    .out_valid (nv),
    .out_sum   (nsum),
    .out_side  (nside)
  );

  lds_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nv),
    .in_sum    (nsum),
    .in_side   (nside),
    .out_valid (rv),
    .out_root  (rroot),
    .out_side  (rside)
  );

  lds_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rv),
    .in_root   (rroot),
    .in_side   (rside),
    .out_valid (qv),
    .out_quo   (qquo),
    .out_side  (qside)
  );

  lds_shade u_shade (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (qv),
    .in_quo     (qquo),
    .in_side    (qside),
    .out_valid  (done),
    .out_result (result)
  );

endmodule
`default_nettype wire

### design/lds_regs.sv
// Configuration register file behind the APB-style port.
// Depends on lds_pkg.
`default_nettype none
module lds_regs import lds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_index_t idx;
  logic       wr;

  assign idx    = reg_index_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_pos_x <= '0;
      cfg.light_pos_y <= '0;
      cfg.light_pos_z <= '0;
      cfg.light_red   <= 8'd255;
      cfg.light_green <= 8'd255;
      cfg.light_blue  <= 8'd255;
      cfg.brightness  <= 9'd256;
    end else if (wr) begin
      case (idx)
        REG_LIGHT_POS_X: cfg.light_pos_x <= pwdata[COORD_WIDTH-1:0];
        REG_LIGHT_POS_Y: cfg.light_pos_y <= pwdata[COORD_WIDTH-1:0];
        REG_LIGHT_POS_Z: cfg.light_pos_z <= pwdata[COORD_WIDTH-1:0];
        REG_LIGHT_RED:   cfg.light_red   <= pwdata[7:0];
        REG_LIGHT_GREEN: cfg.light_green <= pwdata[7:0];
        REG_LIGHT_BLUE:  cfg.light_blue  <= pwdata[7:0];
        REG_BRIGHTNESS:  cfg.brightness  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIGHT_POS_X: prdata = DATA_W'(cfg.light_pos_x);
      REG_LIGHT_POS_Y: prdata = DATA_W'(cfg.light_pos_y);
      REG_LIGHT_POS_Z: prdata = DATA_W'(cfg.light_pos_z);
      REG_LIGHT_RED:   prdata = DATA_W'(cfg.light_red);
      REG_LIGHT_GREEN: prdata = DATA_W'(cfg.light_green);
      REG_LIGHT_BLUE:  prdata = DATA_W'(cfg.light_blue);
      REG_BRIGHTNESS:  prdata = DATA_W'(cfg.brightness);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/lds_norm.sv
// Front of the pipeline: light direction, block normalisation to 30 bits,
// squares and their sum. Depends on lds_pkg and the assertion macros.
`default_nettype none
`include "lambert_diffuse_shade_defines.svh"
module lds_norm import lds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  in_item_t         in_item,
  input  cfg_t             cfg,
  output logic             out_valid,
  output logic [SUM_W-1:0] out_sum,
  output side_t            out_side
);

  logic [COORD_WIDTH-1:0] hit [3];
  logic [COORD_WIDTH-1:0] lpos [3];
  logic [7:0]             obj [3];
  logic [7:0]             lcol [3];
  logic [DIFF_W-1:0]      diff [3];
  logic [DIFF_W-1:0]      mag0 [3];

  // Stage 1: signed difference and magnitude
  logic                  v1;
  logic [DIFF_W-1:0]     mag1 [3];
  logic [2:0]            neg1;
  logic [2:0][NRM_W-1:0] nrm1;
  logic [OC_W-1:0]       oc1 [3];

  always_comb begin
    hit[0]  = in_item.hit_x;
    hit[1]  = in_item.hit_y;
    hit[2]  = in_item.hit_z;
    lpos[0] = cfg.light_pos_x;
    lpos[1] = cfg.light_pos_y;
    lpos[2] = cfg.light_pos_z;
    obj[0]  = in_item.obj_red;
    obj[1]  = in_item.obj_green;
    obj[2]  = in_item.obj_blue;
    lcol[0] = cfg.light_red;
    lcol[1] = cfg.light_green;
    lcol[2] = cfg.light_blue;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {lpos[i][COORD_WIDTH-1], lpos[i]} - {hit[i][COORD_WIDTH-1], hit[i]};
      mag0[i] = diff[i][DIFF_W-1] ? DIFF_W'(~diff[i] + 1'b1) : diff[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= mag0[i];
      neg1[i] <= diff[i][DIFF_W-1];
      oc1[i]  <= {8'b0, obj[i]} * {8'b0, lcol[i]};
    end
    nrm1 <= {in_item.normal_z, in_item.normal_y, in_item.normal_x};
  end

  // Stage 2: bit length of the largest magnitude
  logic [DIFF_W-1:0]   orv;
  logic [BITLEN_W-1:0] bl;

  logic                  v2;
  logic [DIFF_W-1:0]     mag2 [3];
  logic [2:0]            neg2;
  logic [2:0][NRM_W-1:0] nrm2;
  logic [COL_W-1:0]      col2 [3];
  logic [BITLEN_W-1:0]   bl2;
  logic                  zero2;

  always_comb begin
    orv = mag1[0] | mag1[1] | mag1[2];
    bl  = '0;
    for (int i = 0; i < DIFF_W; i++) begin
      if (orv[i]) begin
        bl = BITLEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      mag2[i] <= mag1[i];
      col2[i] <= {9'b0, oc1[i]} * {16'b0, cfg.brightness};
    end
    neg2  <= neg1;
    nrm2  <= nrm1;
    bl2   <= bl;
    zero2 <= (orv == '0);
  end

  // Stage 3: shift so that the largest magnitude has exactly NORM_W bits.
  // Moving up by NORM_W and down by the bit length does both directions.
  logic [DIFF_W+NORM_W-1:0] wide [3];
  side_t                    side3_next;

  logic  v3;
  side_t side3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mag2[i], NORM_W'(0)} >> bl2;
      side3_next.mag[i]    = wide[i][NORM_W-1:0];
      side3_next.colour[i] = col2[i];
    end
    side3_next.neg    = neg2;
    side3_next.zero   = zero2;
    side3_next.normal = nrm2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    side3 <= side3_next;
  end

  // Stage 4: squares
  logic             v4;
  logic [SQ_W-1:0]  sq4 [3];
  side_t            side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 3; i++) begin
      sq4[i] <= {NORM_W'(0), side3.mag[i]} * {NORM_W'(0), side3.mag[i]};
    end
    side4 <= side3;
  end

  // Stage 5: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_sum  <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
    out_side <= side4;
  end

  `LDS_ASSERT_IMP(a_norm_msb, clk, rst, v3 && !side3.zero,
    side3.mag[0][NORM_W-1] || side3.mag[1][NORM_W-1] || side3.mag[2][NORM_W-1])

endmodule
`default_nettype wire

### design/lds_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on lds_pkg and the assertion macros.
`default_nettype none
`include "lambert_diffuse_shade_defines.svh"
module lds_isqrt import lds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic             v [ISQ_STEPS+1];
  logic [SUM_W-1:0] rem [ISQ_STEPS+1];
  logic [RES_W-1:0] res [ISQ_STEPS+1];
  side_t            side [ISQ_STEPS+1];

  assign v[0]    = in_valid;
  assign rem[0]  = in_sum;
  assign res[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam int SH = SUM_W - 2 * k;
    localparam logic [RES_W:0] ONE = 1;
    localparam logic [RES_W:0] STEP_BIT = ONE << SH;

    logic [RES_W:0]   trial;
    logic [SUM_W-1:0] rem_next;
    logic [RES_W-1:0] res_next;

    always_comb begin
      trial = {1'b0, res[k]} + STEP_BIT;
      if ({{(RES_W + 1 - SUM_W){1'b0}}, rem[k]} >= trial) begin
        rem_next = rem[k] - trial[SUM_W-1:0];
        res_next = (res[k] >> 1) + STEP_BIT[RES_W-1:0];
      end else begin
        rem_next = rem[k];
        res_next = res[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      rem[k+1]  <= rem_next;
      res[k+1]  <= res_next;
      side[k+1] <= side[k];
    end
  end

  assign out_valid = v[ISQ_STEPS];
  assign out_root  = res[ISQ_STEPS][ROOT_W-1:0];
  assign out_side  = side[ISQ_STEPS];

  // A normalised direction always has a root between 2^29 and 2^31.
  `LDS_ASSERT_IMP(a_isqrt_range, clk, rst, out_valid && !out_side.zero,
    out_root[ROOT_W-1] || out_root[ROOT_W-2])

endmodule
`default_nettype wire

### design/lds_recip.sv
// Pipelined restoring division giving floor(2^60 / root), one bit per stage.
// Depends on lds_pkg and the assertion macros.
`default_nettype none
`include "lambert_diffuse_shade_defines.svh"
module lds_recip import lds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output side_t             out_side
);

  // The dividend's bits above the quotient width are already below the root.
  localparam logic [ROOT_W-1:0] REM_INIT = ROOT_W'(1) << (2 * NORM_W - QUO_W);

  logic              v [QUO_W+1];
  logic [ROOT_W-1:0] rem [QUO_W+1];
  logic [ROOT_W-1:0] root [QUO_W+1];
  logic [QUO_W-1:0]  quo [QUO_W+1];
  side_t             side [QUO_W+1];

  assign v[0]    = in_valid;
  assign rem[0]  = REM_INIT;
  assign root[0] = in_root;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [ROOT_W:0]   rem2;
    logic [ROOT_W:0]   rdiff;
    logic [ROOT_W-1:0] rem_next;
    logic              qbit;

    always_comb begin
      rem2  = {rem[k], 1'b0};
      rdiff = rem2 - {1'b0, root[k]};
      qbit  = (rem2 >= {1'b0, root[k]});
      rem_next = qbit ? rdiff[ROOT_W-1:0] : rem2[ROOT_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      rem[k+1]  <= rem_next;
      root[k+1] <= root[k];
      quo[k+1]  <= {quo[k][QUO_W-2:0], qbit};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = v[QUO_W];
  assign out_quo   = quo[QUO_W];
  assign out_side  = side[QUO_W];

  // The reciprocal lies in (2^29, 2^31].
  `LDS_ASSERT_IMP(a_recip_range, clk, rst, out_valid && !out_side.zero,
    (out_quo[QUO_W-1:QUO_W-3] != 3'b000) && !(out_quo[QUO_W-1] && (out_quo[QUO_W-2:0] != '0)))

endmodule
`default_nettype wire

### design/lds_shade.sv
// Back of the pipeline: unit direction, clamped dot product with the normal
// and the per-channel colour scale. Depends on lds_pkg and the assertion macros.
`default_nettype none
`include "lambert_diffuse_shade_defines.svh"
module lds_shade import lds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [QUO_W-1:0] in_quo,
  input  side_t            in_side,
  output logic             out_valid,
  output out_item_t        out_result
);

  localparam int PROD_W  = NORM_W + QUO_W;
  localparam int U_SHIFT = 2 * NORM_W - 14;
  localparam int U_W     = PROD_W - U_SHIFT;
  localparam int P_W     = NRM_W + U_W + 1;
  localparam int DSUM_W  = P_W + 2;
  localparam int DOT_W   = 32;
  localparam int NUM_W   = COL_W + DOT_W;
  localparam int T_SHIFT = 36;
  localparam int T_W     = NUM_W - T_SHIFT;
  localparam logic [T_W-1:0] CLAMP_T = T_W'(255 * 256);

  // Stage 1: unit direction magnitude in Q1.14
  logic [PROD_W-1:0] prod [3];
  logic              tv1;
  logic [U_W-1:0]    u1 [3];
  side_t             side1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = PROD_W'(in_side.mag[i]) * PROD_W'(in_quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv1 <= 1'b0;
    end else begin
      tv1 <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      u1[i] <= prod[i][PROD_W-1:U_SHIFT];
    end
    side1 <= in_side;
  end

  // Stage 2: signed products with the normal
  logic signed [U_W:0]   su [3];
  logic signed [P_W-1:0] pr [3];
  logic                  tv2;
  logic signed [P_W-1:0] p2 [3];
  logic [2:0][COL_W-1:0] col2;
  logic                  zero2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      su[i] = side1.neg[i] ? -$signed({1'b0, u1[i]}) : $signed({1'b0, u1[i]});
      pr[i] = $signed(side1.normal[i]) * su[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv2 <= 1'b0;
    end else begin
      tv2 <= tv1;
    end
    for (int i = 0; i < 3; i++) begin
      p2[i] <= pr[i];
    end
    col2  <= side1.colour;
    zero2 <= side1.zero;
  end

  // Stage 3: dot product, negative values and a zero-length direction give 0
  logic signed [DSUM_W-1:0] dsum;
  logic                     tv3;
  logic [DOT_W-1:0]         dot3;
  logic [2:0][COL_W-1:0]    col3;
  logic                     zero3;

  assign dsum = DSUM_W'(p2[0]) + DSUM_W'(p2[1]) + DSUM_W'(p2[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tv3 <= 1'b0;
    end else begin
      tv3 <= tv2;
    end
    dot3  <= (zero2 || dsum[DSUM_W-1]) ? '0 : dsum[DOT_W-1:0];
    col3  <= col2;
    zero3 <= zero2;
  end

  // Stage 4: colour times dot, keeping the part above 2^36
  logic [NUM_W-1:0] num [3];
  logic             tv4;
  logic [T_W-1:0]   t4 [3];
  logic             zero4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'(col3[i]) * NUM_W'(dot3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv4 <= 1'b0;
    end else begin
      tv4 <= tv3;
    end
    for (int i = 0; i < 3; i++) begin
      t4[i] <= num[i][NUM_W-1:T_SHIFT];
    end
    zero4 <= zero3;
  end

  // Stage 5: divide by 255 and clamp. Below 255*256 the value fits in 16 bits,
  // where (x + x/256 + 1) / 256 is exactly x / 255.
  logic [16:0] x17 [3];
  logic [7:0]  chan [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x17[i] = {1'b0, t4[i][15:0]} + {9'b0, t4[i][15:8]} + 17'd1;
      chan[i] = (t4[i] >= CLAMP_T) ? 8'd255 : x17[i][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= tv4;
    end
    out_result.diffuse_red   <= chan[0];
    out_result.diffuse_green <= chan[1];
    out_result.diffuse_blue  <= chan[2];
  end

  `LDS_ASSERT_NXT(a_shade_dark, clk, rst, tv4 && zero4,
    out_valid && (out_result == '0))

endmodule
`default_nettype wire
